FILE: hdl/cfp_pkg.sv
// Shared constants, types and arithmetic helpers of the catheter forward pose pipeline.
`timescale 1ns / 1ps

package cfp_pkg;

    // Word and field widths.
    localparam int WORD_W    = 32;
    localparam int LEN_W     = 31;
    localparam int THR_W     = 28;
    localparam int CFG_IDX_W = 1;
    localparam int ANG_W     = 36;
    localparam int PROD_W    = 34;
    localparam int ROT_W     = 35;
    localparam int WIDE_W    = 40;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SEG_LEN   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'b1;

    // Register reset values.
    localparam logic [LEN_W-1:0] SEG_LEN_RST   = 31'd6553600;
    localparam logic [THR_W-1:0] THRESHOLD_RST = 28'd268;

    // Angle constants in Q3.28.
    localparam logic signed [ANG_W-1:0] WRAP_PI     = 36'sd843314857;
    localparam logic signed [ANG_W-1:0] WRAP_TWO_PI = 36'sd1686629714;
    localparam logic signed [31:0]      ANG_PI      = 32'sd843314857;
    localparam logic signed [31:0]      ANG_HALF_PI = 32'sd421657428;

    // CORDIC arrangement: one fold stage, seven stages of four rotations, one rounding stage.
    localparam int CORDIC_STEPS      = 28;
    localparam int CORDIC_PER_STAGE  = 4;
    localparam int CORDIC_ITER_STGS  = CORDIC_STEPS / CORDIC_PER_STAGE;
    localparam int SC_STAGES         = CORDIC_ITER_STGS + 2;
    localparam int CORDIC_GUARD      = 8;
    localparam int CX_W              = 42;
    localparam logic signed [CX_W-1:0] CORDIC_X0  = 42'sd166920415744;
    localparam logic signed [CX_W-1:0] CORDIC_RND = 42'sd128;

    localparam logic [27:0] ATAN_TAB [CORDIC_STEPS] = '{
        28'd210828714, 28'd124459457, 28'd65760959, 28'd33381290, 28'd16755422,
        28'd8385879, 28'd4193963, 28'd2097109, 28'd1048571, 28'd524287,
        28'd262144, 28'd131072, 28'd65536, 28'd32768, 28'd16384, 28'd8192,
        28'd4096, 28'd2048, 28'd1024, 28'd512, 28'd256, 28'd128, 28'd64,
        28'd32, 28'd16, 28'd8, 28'd4, 28'd2
    };

    // Divider arrangement: 36 quotient bits, four per stage.
    localparam int NUM_W         = 63;
    localparam int DEN_W         = 34;
    localparam int QUO_W         = 36;
    localparam int DIV_PER_STAGE = 4;
    localparam int DIV_STAGES    = QUO_W / DIV_PER_STAGE;

    // Pipeline stage positions.
    localparam int STG_DEC   = 0;
    localparam int STG_SC0   = 1;
    localparam int STG_PROD1 = STG_SC0 + SC_STAGES;
    localparam int STG_PROD2 = STG_PROD1 + 1;
    localparam int STG_DIV0  = STG_PROD1 + 1;
    localparam int STG_SUM   = STG_PROD2 + 1;
    localparam int STG_TIP   = STG_DIV0 + DIV_STAGES;
    localparam int STG_OUT   = STG_TIP + 1;
    localparam int N_STG     = STG_OUT + 1;
    localparam int ROT_STGS  = STG_TIP - STG_SUM + 1;

    // Q1.0 constant in Q2.30.
    localparam logic signed [ROT_W-1:0] ONE_Q30 = 35'sd1073741824;

    // Reduce an angle to [-pi, pi) by picking the one representative in range.
    function automatic logic signed [31:0] wrap_pi(input logic signed [ANG_W-1:0] v);
        logic signed [ANG_W-1:0] c;
        logic signed [31:0]      res;
        res = '0;
        for (int k = -3; k <= 3; k++) begin
            c = v - ANG_W'(k) * WRAP_TWO_PI;
            if (c >= -WRAP_PI && c < WRAP_PI) begin
                res = c[31:0];
            end
        end
        return res;
    endfunction

    // Q2.30 product rounded half up.
    function automatic logic signed [PROD_W-1:0] mul30(input logic signed [PROD_W-1:0] a,
                                                       input logic signed [PROD_W-1:0] b);
        logic signed [2*PROD_W-1:0] p;
        p = a * b;
        p = p + (68'sd1 <<< 29);
        p = p >>> 30;
        return p[PROD_W-1:0];
    endfunction

    // Clamp a wide value to the signed word range.
    function automatic logic signed [WORD_W-1:0] sat(input logic signed [WIDE_W-1:0] v);
        logic signed [WORD_W-1:0] res;
        if (v > 40'sd2147483647) begin
            res = 32'sh7FFFFFFF;
        end else if (v < -40'sd2147483648) begin
            res = 32'sh80000000;
        end else begin
            res = v[WORD_W-1:0];
        end
        return res;
    endfunction

    // Values that travel alongside an item.
    typedef struct packed {
        logic signed [WORD_W-1:0] d;
        logic                     bent;
        logic [WORD_W-1:0]        a;
        logic signed [WORD_W-1:0] cgt;
        logic signed [WORD_W-1:0] sgt;
        logic                     s2neg;
    } t_side;

endpackage

FILE: hdl/cfp_in_if.sv
// Input channel of the forward pose block: one joint configuration per item.
`timescale 1ns / 1ps

interface cfp_in_if;
    import cfp_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [WORD_W-1:0] roll_angle;
    logic signed [WORD_W-1:0] bend_axis_angle;
    logic signed [WORD_W-1:0] bend_angle;
    logic signed [WORD_W-1:0] translation;

    modport source (output valid, roll_angle, bend_axis_angle, bend_angle, translation,
                    input ready);
    modport sink (input valid, roll_angle, bend_axis_angle, bend_angle, translation,
                  output ready);
endinterface

FILE: hdl/cfp_out_if.sv
// Output channel of the forward pose block: one 3x4 pose per item.
`timescale 1ns / 1ps

interface cfp_out_if;
    import cfp_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [WORD_W-1:0] rot_r0c0;
    logic signed [WORD_W-1:0] rot_r0c1;
    logic signed [WORD_W-1:0] rot_r0c2;
    logic signed [WORD_W-1:0] rot_r1c0;
    logic signed [WORD_W-1:0] rot_r1c1;
    logic signed [WORD_W-1:0] rot_r1c2;
    logic signed [WORD_W-1:0] rot_r2c0;
    logic signed [WORD_W-1:0] rot_r2c1;
    logic signed [WORD_W-1:0] rot_r2c2;
    logic signed [WORD_W-1:0] tip_x;
    logic signed [WORD_W-1:0] tip_y;
    logic signed [WORD_W-1:0] tip_z;

    modport source (output valid, rot_r0c0, rot_r0c1, rot_r0c2, rot_r1c0, rot_r1c1, rot_r1c2,
                    rot_r2c0, rot_r2c1, rot_r2c2, tip_x, tip_y, tip_z, input ready);
    modport sink (input valid, rot_r0c0, rot_r0c1, rot_r0c2, rot_r1c0, rot_r1c1, rot_r1c2,
                  rot_r2c0, rot_r2c1, rot_r2c2, tip_x, tip_y, tip_z, output ready);
endinterface

FILE: hdl/cfp_sincos.sv
// Pipelined CORDIC sine and cosine: angle wrap and fold, 28 rotations, rounding.
`timescale 1ns / 1ps

module cfp_sincos import cfp_pkg::*; (
    input  logic                     i_clk,
    input  logic [SC_STAGES-1:0]     i_en,
    input  logic signed [ANG_W-1:0]  i_angle,
    output logic signed [WORD_W-1:0] o_sin,
    output logic signed [WORD_W-1:0] o_cos
);

    logic signed [CX_W-1:0]   r_x   [CORDIC_ITER_STGS+1];
    logic signed [CX_W-1:0]   r_y   [CORDIC_ITER_STGS+1];
    logic signed [31:0]       r_z   [CORDIC_ITER_STGS+1];
    logic                     r_neg [CORDIC_ITER_STGS+1];
    logic signed [CX_W-1:0]   n_x   [CORDIC_ITER_STGS+1];
    logic signed [CX_W-1:0]   n_y   [CORDIC_ITER_STGS+1];
    logic signed [31:0]       n_z   [CORDIC_ITER_STGS+1];
    logic                     n_neg [CORDIC_ITER_STGS+1];
    logic signed [WORD_W-1:0] r_sin, r_cos, n_sin, n_cos;

    // Fold stage and the rotation stages.
    always_comb begin
        logic signed [31:0]     w;
        logic signed [CX_W-1:0] tx, ty, dx, dy;
        logic signed [31:0]     tz, at;
        int                     i;
        // Wrap to [-pi, pi), then fold the outer quarters onto the inner half.
        w = wrap_pi(i_angle);
        n_x[0] = CORDIC_X0;
        n_y[0] = '0;
        if (w > ANG_HALF_PI) begin
            n_z[0]   = w - ANG_PI;
            n_neg[0] = 1'b1;
        end else if (w < -ANG_HALF_PI) begin
            n_z[0]   = w + ANG_PI;
            n_neg[0] = 1'b1;
        end else begin
            n_z[0]   = w;
            n_neg[0] = 1'b0;
        end
        // Each stage applies four rotations to the previous stage's vector.
        for (int s = 1; s <= CORDIC_ITER_STGS; s++) begin
            tx = r_x[s-1];
            ty = r_y[s-1];
            tz = r_z[s-1];
            for (int j = 0; j < CORDIC_PER_STAGE; j++) begin
                i  = (s - 1) * CORDIC_PER_STAGE + j;
                dx = ty >>> i;
                dy = tx >>> i;
                at = signed'(32'(ATAN_TAB[i]));
                if (tz >= 0) begin
                    tx = tx - dx;
                    ty = ty + dy;
                    tz = tz - at;
                end else begin
                    tx = tx + dx;
                    ty = ty - dy;
                    tz = tz + at;
                end
            end
            n_x[s]   = tx;
            n_y[s]   = ty;
            n_z[s]   = tz;
            n_neg[s] = r_neg[s-1];
        end
    end

    // Rounding stage: drop the guard bits and undo the fold.
    always_comb begin
        logic signed [CX_W-1:0]   xr, yr;
        logic signed [WORD_W-1:0] c32, s32;
        xr  = (r_x[CORDIC_ITER_STGS] + CORDIC_RND) >>> CORDIC_GUARD;
        yr  = (r_y[CORDIC_ITER_STGS] + CORDIC_RND) >>> CORDIC_GUARD;
        c32 = xr[WORD_W-1:0];
        s32 = yr[WORD_W-1:0];
        n_cos = r_neg[CORDIC_ITER_STGS] ? -c32 : c32;
        n_sin = r_neg[CORDIC_ITER_STGS] ? -s32 : s32;
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s <= CORDIC_ITER_STGS; s++) begin
            if (i_en[s]) begin
                r_x[s]   <= n_x[s];
                r_y[s]   <= n_y[s];
                r_z[s]   <= n_z[s];
                r_neg[s] <= n_neg[s];
            end
        end
        if (i_en[SC_STAGES-1]) begin
            r_sin <= n_sin;
            r_cos <= n_cos;
        end
    end

    assign o_sin = r_sin;
    assign o_cos = r_cos;

endmodule

FILE: hdl/cfp_div.sv
// Pipelined restoring divider: four quotient bits per stage.
`timescale 1ns / 1ps

module cfp_div import cfp_pkg::*; (
    input  logic                  i_clk,
    input  logic [DIV_STAGES-1:0] i_en,
    input  logic [NUM_W-1:0]      i_num,
    input  logic [DEN_W-1:0]      i_den,
    output logic [QUO_W-1:0]      o_quo
);

    logic [DEN_W-1:0] r_rem [DIV_STAGES];
    logic [QUO_W-1:0] r_quo [DIV_STAGES];
    logic [QUO_W-1:0] r_low [DIV_STAGES];
    logic [DEN_W-1:0] r_den [DIV_STAGES];
    logic [DEN_W-1:0] n_rem [DIV_STAGES];
    logic [QUO_W-1:0] n_quo [DIV_STAGES];

    // Each stage shifts in four dividend bits and settles four quotient bits.
    always_comb begin
        logic [DEN_W-1:0] rem, den;
        logic [QUO_W-1:0] quo, low;
        logic [DEN_W:0]   t;
        int               b;
        for (int s = 0; s < DIV_STAGES; s++) begin
            if (s == 0) begin
                rem = DEN_W'(i_num[NUM_W-1:QUO_W]);
                quo = '0;
                low = i_num[QUO_W-1:0];
                den = i_den;
            end else begin
                rem = r_rem[s-1];
                quo = r_quo[s-1];
                low = r_low[s-1];
                den = r_den[s-1];
            end
            for (int j = 0; j < DIV_PER_STAGE; j++) begin
                b = QUO_W - 1 - (s * DIV_PER_STAGE + j);
                t = {rem, low[b]};
                if (t >= {1'b0, den}) begin
                    t      = t - {1'b0, den};
                    quo[b] = 1'b1;
                end
                rem = t[DEN_W-1:0];
            end
            n_rem[s] = rem;
            n_quo[s] = quo;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < DIV_STAGES; s++) begin
            if (i_en[s]) begin
                r_rem[s] <= n_rem[s];
                r_quo[s] <= n_quo[s];
                r_low[s] <= (s == 0) ? i_num[QUO_W-1:0] : r_low[s-1];
                r_den[s] <= (s == 0) ? i_den : r_den[s-1];
            end
        end
    end

    assign o_quo = r_quo[DIV_STAGES-1];

endmodule

FILE: hdl/catheter_forward_pose.sv
// Forward pose of a constant-curvature bending segment: top-level pipeline.
// Throughput: one item per cycle; the input stalls only when all 22 stages hold items
// and the output is not taken. The three CORDIC units and the two dividers set the depth.
// Reset (synchronous, active low) empties every stage and restores the segment length
// to 100 mm and the small-angle threshold to 268.
`timescale 1ns / 1ps

module catheter_forward_pose import cfp_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [LEN_W-1:0]     i_cfg_data,
    cfp_in_if.sink               i_pose_in,
    cfp_out_if.source            o_pose_out
);

    // Product slots of the first multiplier stage.
    localparam int P_SGT_ST = 0;
    localparam int P_CGT_CT = 1;
    localparam int P_CGT_ST = 2;
    localparam int P_SGT_CT = 3;
    localparam int P_CGT_SA = 4;
    localparam int P_SGT_SA = 5;
    localparam int P_CT_SA  = 6;
    localparam int P_ST_SA  = 7;
    localparam int N_PROD   = 8;
    localparam int N_ROT    = 9;
    localparam int N_OUT    = 12;

    logic [LEN_W-1:0] r_seg_len;
    logic [THR_W-1:0] r_thr;
    logic [N_STG-1:0] r_vld;
    logic [N_STG-1:0] w_en;
    t_side            r_side [STG_TIP+1];
    t_side            w_side10;

    // Decode stage.
    logic signed [ANG_W-1:0] r_ang0, r_ang1, r_ang2, n_ang0, n_ang1, n_ang2;
    t_side                   n_side0;

    // Trig results.
    logic signed [WORD_W-1:0] w_s0, w_c0, w_s1, w_c1, w_s2, w_c2;

    // Multiplier stages.
    logic signed [PROD_W-1:0] r_p   [N_PROD];
    logic signed [PROD_W-1:0] n_p   [N_PROD];
    logic signed [PROD_W-1:0] r_p11 [N_PROD];
    logic signed [PROD_W-1:0] r_q   [4];
    logic signed [PROD_W-1:0] n_q   [4];
    logic signed [WORD_W-1:0] r_ca10, r_ca11;
    logic [NUM_W-1:0]         r_num1, r_num2, n_num1, n_num2;
    logic [DEN_W-1:0]         r_den;

    // Rotation, tip and output stages.
    logic signed [ROT_W-1:0]  r_rot [ROT_STGS][N_ROT];
    logic signed [ROT_W-1:0]  n_rot [N_ROT];
    logic signed [WIDE_W-1:0] r_tip [3];
    logic signed [WIDE_W-1:0] n_tip [3];
    logic signed [WORD_W-1:0] r_out [N_OUT];
    logic [QUO_W-1:0]         w_quo1, w_quo2;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg_len <= SEG_LEN_RST;
            r_thr     <= THRESHOLD_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_SEG_LEN:   r_seg_len <= i_cfg_data;
                REG_THRESHOLD: r_thr     <= i_cfg_data[THR_W-1:0];
                default: ;
            endcase
        end
    end

    // A stage loads when it is empty or the stage after it moves on.
    always_comb begin
        w_en[N_STG-1] = ~r_vld[N_STG-1] | o_pose_out.ready;
        for (int k = N_STG - 2; k >= 0; k--) begin
            w_en[k] = ~r_vld[k] | w_en[k+1];
        end
    end

    assign i_pose_in.ready = w_en[STG_DEC];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_pose_in.valid;
            end
            for (int k = 1; k < N_STG; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Decode: flip a negative bend, turn the bending plane by pi, pick the CORDIC angles.
    always_comb begin
        logic signed [32:0]       a_ext, a_abs;
        logic [WORD_W-1:0]        a_mag;
        logic signed [WORD_W-1:0] t_wr, t_sel;
        logic                     a_neg, bent;
        a_neg = i_pose_in.bend_angle[WORD_W-1];
        a_ext = 33'(i_pose_in.bend_angle);
        a_abs = a_neg ? -a_ext : a_ext;
        a_mag = a_abs[WORD_W-1:0];
        t_wr  = wrap_pi(ANG_W'(i_pose_in.bend_axis_angle) + WRAP_PI);
        t_sel = a_neg ? t_wr : i_pose_in.bend_axis_angle;
        bent  = a_mag > WORD_W'(r_thr);
        n_ang0 = bent ? ANG_W'(i_pose_in.roll_angle) + ANG_W'(t_sel)
                      : ANG_W'(i_pose_in.roll_angle);
        n_ang1 = ANG_W'(t_sel);
        n_ang2 = signed'(ANG_W'(a_mag));
        n_side0       = '0;
        n_side0.d     = i_pose_in.translation;
        n_side0.bent  = bent;
        n_side0.a     = a_mag;
    end

    always_ff @(posedge i_clk) begin
        if (w_en[STG_DEC]) begin
            r_ang0 <= n_ang0;
            r_ang1 <= n_ang1;
            r_ang2 <= n_ang2;
        end
    end

    // Three CORDIC units: roll plus plane (or roll alone when straight), plane, bend.
    cfp_sincos u_sc_gt (
        .i_clk   (i_clk),
        .i_en    (w_en[STG_SC0 +: SC_STAGES]),
        .i_angle (r_ang0),
        .o_sin   (w_s0),
        .o_cos   (w_c0)
    );

    cfp_sincos u_sc_t (
        .i_clk   (i_clk),
        .i_en    (w_en[STG_SC0 +: SC_STAGES]),
        .i_angle (r_ang1),
        .o_sin   (w_s1),
        .o_cos   (w_c1)
    );

    cfp_sincos u_sc_a (
        .i_clk   (i_clk),
        .i_en    (w_en[STG_SC0 +: SC_STAGES]),
        .i_angle (r_ang2),
        .o_sin   (w_s2),
        .o_cos   (w_c2)
    );

    // First products, and the two rounded dividends of the arc formulas.
    always_comb begin
        logic signed [33:0] omc_s;
        logic [32:0]        omc;
        logic signed [32:0] sa_e, sa_abs;
        logic [63:0]        half_den;
        n_p[P_SGT_ST] = mul30(PROD_W'(w_s0), PROD_W'(w_s1));
        n_p[P_CGT_CT] = mul30(PROD_W'(w_c0), PROD_W'(w_c1));
        n_p[P_CGT_ST] = mul30(PROD_W'(w_c0), PROD_W'(w_s1));
        n_p[P_SGT_CT] = mul30(PROD_W'(w_s0), PROD_W'(w_c1));
        n_p[P_CGT_SA] = mul30(PROD_W'(w_c0), PROD_W'(w_s2));
        n_p[P_SGT_SA] = mul30(PROD_W'(w_s0), PROD_W'(w_s2));
        n_p[P_CT_SA]  = mul30(PROD_W'(w_c1), PROD_W'(w_s2));
        n_p[P_ST_SA]  = mul30(PROD_W'(w_s1), PROD_W'(w_s2));
        // One minus cosine never goes below zero.
        omc_s    = 34'sd1073741824 - 34'(w_c2);
        omc      = (omc_s < 0) ? '0 : omc_s[32:0];
        sa_e     = 33'(w_s2);
        sa_abs   = w_s2[WORD_W-1] ? -sa_e : sa_e;
        half_den = 64'({r_side[STG_PROD1-1].a, 1'b0});
        n_num1   = NUM_W'(64'(r_seg_len) * 64'(omc) + half_den);
        n_num2   = NUM_W'(64'(r_seg_len) * 64'(unsigned'(sa_abs)) + half_den);
        w_side10       = r_side[STG_PROD1-1];
        w_side10.cgt   = w_c0;
        w_side10.sgt   = w_s0;
        w_side10.s2neg = w_s2[WORD_W-1];
    end

    always_ff @(posedge i_clk) begin
        if (w_en[STG_PROD1]) begin
            r_p    <= n_p;
            r_ca10 <= w_c2;
            r_num1 <= n_num1;
            r_num2 <= n_num2;
            r_den  <= {r_side[STG_PROD1-1].a, 2'b00};
        end
    end

    // Second products: terms scaled by the cosine of the bend.
    always_comb begin
        n_q[0] = mul30(r_p[P_CGT_CT], PROD_W'(r_ca10));
        n_q[1] = mul30(r_p[P_CGT_ST], PROD_W'(r_ca10));
        n_q[2] = mul30(r_p[P_SGT_CT], PROD_W'(r_ca10));
        n_q[3] = mul30(r_p[P_SGT_ST], PROD_W'(r_ca10));
    end

    always_ff @(posedge i_clk) begin
        if (w_en[STG_PROD2]) begin
            r_p11  <= r_p;
            r_q    <= n_q;
            r_ca11 <= r_ca10;
        end
    end

    // Arc radius and axial reach, both rounded half away from zero.
    cfp_div u_div_rad (
        .i_clk (i_clk),
        .i_en  (w_en[STG_DIV0 +: DIV_STAGES]),
        .i_num (r_num1),
        .i_den (r_den),
        .o_quo (w_quo1)
    );

    cfp_div u_div_ax (
        .i_clk (i_clk),
        .i_en  (w_en[STG_DIV0 +: DIV_STAGES]),
        .i_num (r_num2),
        .i_den (r_den),
        .o_quo (w_quo2)
    );

    // Rotation sums, or a pure roll about z for a straight segment.
    always_comb begin
        t_side s;
        s = r_side[STG_SUM-1];
        if (s.bent) begin
            n_rot[0] = ROT_W'(r_p11[P_SGT_ST]) + ROT_W'(r_q[0]);
            n_rot[1] = ROT_W'(r_q[1]) - ROT_W'(r_p11[P_SGT_CT]);
            n_rot[2] = ROT_W'(r_p11[P_CGT_SA]);
            n_rot[3] = ROT_W'(r_q[2]) - ROT_W'(r_p11[P_CGT_ST]);
            n_rot[4] = ROT_W'(r_p11[P_CGT_CT]) + ROT_W'(r_q[3]);
            n_rot[5] = ROT_W'(r_p11[P_SGT_SA]);
            n_rot[6] = -ROT_W'(r_p11[P_CT_SA]);
            n_rot[7] = -ROT_W'(r_p11[P_ST_SA]);
            n_rot[8] = ROT_W'(r_ca11);
        end else begin
            n_rot[0] = ROT_W'(s.cgt);
            n_rot[1] = -ROT_W'(s.sgt);
            n_rot[2] = '0;
            n_rot[3] = ROT_W'(s.sgt);
            n_rot[4] = ROT_W'(s.cgt);
            n_rot[5] = '0;
            n_rot[6] = '0;
            n_rot[7] = '0;
            n_rot[8] = ONE_Q30;
        end
    end

    // Tip position from the quotients, or straight along z by the segment length when straight.
    always_comb begin
        t_side                   s;
        logic signed [QUO_W:0]   rad, ax;
        logic signed [68:0]      px, py;
        logic signed [WIDE_W-1:0] axs;
        s   = r_side[STG_TIP-1];
        rad = signed'({1'b0, w_quo1});
        ax  = signed'({1'b0, w_quo2});
        px  = rad * s.cgt;
        py  = rad * s.sgt;
        px  = (px + 69'sd536870912) >>> 30;
        py  = (py + 69'sd536870912) >>> 30;
        axs = s.s2neg ? -WIDE_W'(ax) : WIDE_W'(ax);
        if (s.bent) begin
            n_tip[0] = px[WIDE_W-1:0];
            n_tip[1] = py[WIDE_W-1:0];
            n_tip[2] = WIDE_W'(s.d) + axs;
        end else begin
            n_tip[0] = '0;
            n_tip[1] = '0;
            n_tip[2] = WIDE_W'(s.d) + signed'(WIDE_W'(r_seg_len));
        end
    end

    // Sideband, rotation carry, tip and saturated output registers.
    always_ff @(posedge i_clk) begin
        if (w_en[STG_DEC]) begin
            r_side[0] <= n_side0;
        end
        for (int k = 1; k <= STG_TIP; k++) begin
            if (w_en[k]) begin
                r_side[k] <= (k == STG_PROD1) ? w_side10 : r_side[k-1];
            end
        end
        if (w_en[STG_SUM]) begin
            r_rot[0] <= n_rot;
        end
        for (int k = 1; k < ROT_STGS; k++) begin
            if (w_en[STG_SUM+k]) begin
                r_rot[k] <= r_rot[k-1];
            end
        end
        if (w_en[STG_TIP]) begin
            r_tip <= n_tip;
        end
        if (w_en[STG_OUT]) begin
            for (int k = 0; k < N_ROT; k++) begin
                r_out[k] <= sat(WIDE_W'(r_rot[ROT_STGS-1][k]));
            end
            for (int k = 0; k < 3; k++) begin
                r_out[N_ROT+k] <= sat(r_tip[k]);
            end
        end
    end

    assign o_pose_out.valid    = r_vld[STG_OUT];
    assign o_pose_out.rot_r0c0 = r_out[0];
    assign o_pose_out.rot_r0c1 = r_out[1];
    assign o_pose_out.rot_r0c2 = r_out[2];
    assign o_pose_out.rot_r1c0 = r_out[3];
    assign o_pose_out.rot_r1c1 = r_out[4];
    assign o_pose_out.rot_r1c2 = r_out[5];
    assign o_pose_out.rot_r2c0 = r_out[6];
    assign o_pose_out.rot_r2c1 = r_out[7];
    assign o_pose_out.rot_r2c2 = r_out[8];
    assign o_pose_out.tip_x    = r_out[9];
    assign o_pose_out.tip_y    = r_out[10];
    assign o_pose_out.tip_z    = r_out[11];

    // The input only stalls when every stage holds an item.
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_pose_in.ready |-> (&r_vld))
        else $error("input stalled with an empty stage");

    // A held item in the decode stage is not dropped.
    a_dec_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[STG_DEC] && !w_en[STG_DEC]) |=> r_vld[STG_DEC])
        else $error("decode stage lost an item");

    // A bent item never reaches the dividers with a zero divisor.
    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[STG_PROD1] && r_side[STG_PROD1].bent) |-> (r_den != '0))
        else $error("zero divisor on a bent item");

    // A straight segment has its tip on the z axis.
    a_straight_tip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[STG_TIP] && !r_side[STG_TIP].bent) |-> (r_tip[0] == '0 && r_tip[1] == '0))
        else $error("straight segment with an off-axis tip");

endmodule

FILE: tb/cfp_pose_checker.sv
// Pose checker: predicts each pose from the accepted configurations and compares the results.
`timescale 1ns / 1ps

module cfp_pose_checker import cfp_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [LEN_W-1:0]     i_cfg_data,
    cfp_in_if.sink               i_pose_in,
    cfp_out_if.sink              o_pose_out,
    output int                   o_fail_count,
    output int                   o_pending
);

    typedef struct {
        longint val [12];
    } t_pose;

    localparam longint TWO_PI_Q28  = 64'sd1686629714;
    localparam longint PI_Q28      = 64'sd843314857;
    localparam longint HALF_PI_Q28 = 64'sd421657428;
    localparam longint UNIT_Q30    = 64'sd1073741824;
    localparam longint GAIN_Q30    = 64'sd652032874;

    localparam longint ARCTAN_Q28 [28] = '{
        210828714, 124459457, 65760959, 33381290, 16755422, 8385879, 4193963,
        2097109, 1048571, 524287, 262144, 131072, 65536, 32768, 16384, 8192,
        4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2
    };

    longint seg_len_q16;
    longint straight_limit;
    t_pose  expected_poses [$];
    int     fail_count;

    assign o_fail_count = fail_count;
    assign o_pending    = expected_poses.size();

    // Division by a power of two, rounded half up; >>> on longint is arithmetic.
    function automatic longint round_half_up(longint v, int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint wrap_angle(longint v);
        longint m;
        m = v % TWO_PI_Q28;
        if (m < 0) m += TWO_PI_Q28;
        if (m >= PI_Q28) m -= TWO_PI_Q28;
        return m;
    endfunction

    // Rotation by CORDIC after folding the angle into the right half plane.
    function automatic void angle_to_sin_cos(longint ang, output longint s, output longint c);
        longint z, x, y, dx, dy;
        bit     folded;
        z = wrap_angle(ang);
        x = GAIN_Q30 <<< 8;
        y = 0;
        folded = 0;
        if (z > HALF_PI_Q28) begin
            z -= PI_Q28;
            folded = 1;
        end else if (z < -HALF_PI_Q28) begin
            z += PI_Q28;
            folded = 1;
        end
        for (int i = 0; i < 28; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx;
                y += dy;
                z -= ARCTAN_Q28[i];
            end else begin
                x += dx;
                y -= dy;
                z += ARCTAN_Q28[i];
            end
        end
        x = round_half_up(x, 8);
        y = round_half_up(y, 8);
        c = folded ? -x : x;
        s = folded ? -y : y;
    endfunction

    function automatic longint q30_mul(longint a, longint b);
        return round_half_up(a * b, 30);
    endfunction

    // Division rounded half away from zero; the divisor is always positive.
    function automatic longint div_nearest(longint num, longint den);
        longint mag, q;
        mag = num < 0 ? -num : num;
        q = (mag + den / 2) / den;
        return num < 0 ? -q : q;
    endfunction

    function automatic longint clamp_word(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic t_pose predict_pose(longint g, longint t, longint a, longint d,
                                           longint len, longint thr);
        t_pose  p;
        longint sgt, cgt, st, ct, sa, ca, omc, rad, den;
        if (a < 0) begin
            a = -a;
            t = wrap_angle(t + PI_Q28);
        end
        if (a > thr) begin
            angle_to_sin_cos(g + t, sgt, cgt);
            angle_to_sin_cos(t, st, ct);
            angle_to_sin_cos(a, sa, ca);
            p.val[0] = q30_mul(sgt, st) + q30_mul(q30_mul(cgt, ct), ca);
            p.val[1] = -q30_mul(sgt, ct) + q30_mul(q30_mul(cgt, st), ca);
            p.val[2] = q30_mul(cgt, sa);
            p.val[3] = -q30_mul(cgt, st) + q30_mul(q30_mul(sgt, ct), ca);
            p.val[4] = q30_mul(cgt, ct) + q30_mul(q30_mul(sgt, st), ca);
            p.val[5] = q30_mul(sgt, sa);
            p.val[6] = -q30_mul(ct, sa);
            p.val[7] = -q30_mul(st, sa);
            p.val[8] = ca;
            omc = UNIT_Q30 - ca;
            if (omc < 0) omc = 0;
            den = a * 4;
            rad = div_nearest(len * omc, den);
            p.val[9]  = round_half_up(rad * cgt, 30);
            p.val[10] = round_half_up(rad * sgt, 30);
            p.val[11] = d + div_nearest(len * sa, den);
        end else begin
            angle_to_sin_cos(g, sgt, cgt);
            p.val = '{cgt, -sgt, 0, sgt, cgt, 0, 0, 0, UNIT_Q30, 0, 0, d + len};
        end
        foreach (p.val[k]) p.val[k] = clamp_word(p.val[k]);
        return p;
    endfunction

    // Register shadow, expectation on each accepted item, comparison on each result.
    always @(posedge i_clk) begin
        t_pose  want;
        longint act [12];
        if (!i_rst_n) begin
            seg_len_q16    <= 64'd6553600;
            straight_limit <= 64'd268;
            expected_poses.delete();
            fail_count     = 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_SEG_LEN) seg_len_q16 <= longint'(i_cfg_data);
                else if (i_cfg_idx == REG_THRESHOLD)
                    straight_limit <= longint'(i_cfg_data[THR_W-1:0]);
            end
            if (i_pose_in.valid && i_pose_in.ready) begin
                expected_poses.push_back(predict_pose(
                    longint'(i_pose_in.roll_angle), longint'(i_pose_in.bend_axis_angle),
                    longint'(i_pose_in.bend_angle), longint'(i_pose_in.translation),
                    seg_len_q16, straight_limit));
            end
            if (o_pose_out.valid && o_pose_out.ready) begin
                act = '{o_pose_out.rot_r0c0, o_pose_out.rot_r0c1, o_pose_out.rot_r0c2,
                        o_pose_out.rot_r1c0, o_pose_out.rot_r1c1, o_pose_out.rot_r1c2,
                        o_pose_out.rot_r2c0, o_pose_out.rot_r2c1, o_pose_out.rot_r2c2,
                        o_pose_out.tip_x, o_pose_out.tip_y, o_pose_out.tip_z};
                if (expected_poses.size() == 0) begin
                    if (fail_count < 10) $display("Unexpected pose at %0t", $realtime);
                    fail_count = fail_count + 1;
                end else begin
                    want = expected_poses.pop_front();
                    foreach (act[k]) begin
                        if (act[k] != want.val[k]) begin
                            if (fail_count < 10)
                                $display("Pose field %0d mismatch: expected %0d, got %0d",
                                         k, want.val[k], act[k]);
                            fail_count = fail_count + 1;
                        end
                    end
                end
            end
        end
    end

endmodule

FILE: tb/catheter_forward_pose_tb.sv
// Testbench top: drives configurations and registers, paces the output and gives the verdict.
`timescale 1ns / 1ps

module catheter_forward_pose_tb;
    import cfp_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 40;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [LEN_W-1:0]     i_cfg_data;
    int                   fail_count;
    int                   pending;
    int                   idle_cycles;
    bit                   calm_phase;
    bit                   long_hold;

    cfp_in_if  pose_in ();
    cfp_out_if pose_out ();

    catheter_forward_pose u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pose_in  (pose_in.sink),
        .o_pose_out (pose_out.source)
    );

    cfp_pose_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_pose_in    (pose_in.sink),
        .o_pose_out   (pose_out.sink),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Random angle, mostly within [-pi, pi], sometimes near zero, sometimes any word.
    function automatic logic [31:0] rand_angle();
        case ($urandom_range(0, 7))
            0:       return $urandom();
            1:       return $urandom_range(0, 600);
            2:       return -$urandom_range(0, 600);
            default: return $signed($urandom_range(0, 32'd1686629714)) - 32'sd843314857;
        endcase
    endfunction

    // Offer one item and hold it until it is accepted, then at times pause before the next.
    task automatic send_pose(logic [31:0] g, logic [31:0] t, logic [31:0] a, logic [31:0] d);
        pose_in.valid           <= 1'b1;
        pose_in.roll_angle      <= g;
        pose_in.bend_axis_angle <= t;
        pose_in.bend_angle      <= a;
        pose_in.translation     <= d;
        do @(posedge i_clk); while (!pose_in.ready);
        @(negedge i_clk);
        if (!calm_phase && $urandom_range(0, 5) == 0) begin
            pose_in.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
        end
    endtask

    task automatic send_random_pose();
        logic [31:0] d;
        d = $urandom_range(0, 3) == 0 ? $urandom() : $signed($urandom_range(0, 20000000)) - 10000000;
        send_pose(rand_angle(), rand_angle(), rand_angle(), d);
    endtask

    // Wait until every expected pose has arrived, then let the pipeline settle.
    task automatic drain();
        pose_in.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [LEN_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // Receiver: random stall bursts, one long hold-off on request, none at the end.
    initial begin
        pose_out.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold) begin
                pose_out.ready <= 1'b0;
                repeat (60) @(negedge i_clk);
                long_hold = 1'b0;
            end
            if (!calm_phase && $urandom_range(0, 4) == 0) begin
                pose_out.ready <= 1'b0;
                repeat ($urandom_range(1, 8) - 1) @(negedge i_clk);
            end else begin
                pose_out.ready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles without any accepted item.
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((pose_in.valid && pose_in.ready) || (pose_out.valid && pose_out.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n                 = 1'b0;
        i_cfg_we                = 1'b0;
        i_cfg_idx               = REG_SEG_LEN;
        i_cfg_data              = '0;
        pose_in.valid           = 1'b0;
        pose_in.roll_angle      = '0;
        pose_in.bend_axis_angle = '0;
        pose_in.bend_angle      = '0;
        pose_in.translation     = '0;
        calm_phase              = 1'b0;
        long_hold               = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: field extremes, flipped and straight bends, wide angles.
        send_pose(0, 0, 0, 0);
        send_pose(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
        send_pose(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
        send_pose(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
        send_pose(0, 0, 268, 0);
        send_pose(0, 0, 269, 0);
        send_pose(0, 0, -268, 0);
        send_pose(0, 0, -269, 100);
        send_pose(32'd421657428, 32'd843314857, 32'd843314857, 0);
        send_pose(-32'd843314857, -32'd843314857, -32'd843314857, -5);
        send_pose(32'd1686629714, 32'd100, 32'd1686629714, 32'h7FFF0000);
        send_pose(32'd123456789, 32'd987654321, 32'd300000000, 32'h80000001);
        drain();

        // Extreme registers, incl. threshold zero and unused data bits.
        write_reg(REG_SEG_LEN, 31'h7FFFFFFF);
        write_reg(REG_THRESHOLD, 31'h7FFFFFFF);
        send_pose(0, 0, 32'h0FFFFFFF, 32'h7FFFFFFF);
        send_pose(0, 0, 32'h10000000, 32'h7FFFFFFF);
        send_pose(5, 5, 32'h80000000, 32'h80000000);
        drain();
        write_reg(REG_THRESHOLD, 0);
        write_reg(REG_SEG_LEN, 0);
        send_pose(0, 0, 0, 7);
        send_pose(0, 0, 1, 7);
        send_pose(0, 0, -1, 7);
        send_pose(1, 2, 32'h7FFFFFFF, -7);
        drain();

        // Random phases over several register settings.
        for (int ph = 0; ph < 5; ph++) begin
            write_reg(REG_SEG_LEN, ph == 0 ? 31'h7FFFFFFF : $urandom());
            write_reg(REG_THRESHOLD, ph == 1 ? 31'h0FFFFFFF : $urandom_range(0, 4000));
            if (ph == 2) long_hold = 1'b1;
            if (ph == 4) calm_phase = 1'b1;
            for (int n = 0; n < 125; n++) send_random_pose();
            drain();
        end

        // Return to the reset values.
        write_reg(REG_SEG_LEN, 31'd6553600);
        write_reg(REG_THRESHOLD, 31'd268);
        for (int n = 0; n < 20; n++) send_random_pose();
        drain();

        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

FILE: files.f
hdl/cfp_pkg.sv
hdl/cfp_in_if.sv
hdl/cfp_out_if.sv
hdl/cfp_sincos.sv
hdl/cfp_div.sv
hdl/catheter_forward_pose.sv
tb/cfp_pose_checker.sv
tb/catheter_forward_pose_tb.sv
